/* design/bmsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsh_pkg
// Shared types and constants of the button matrix scan history block.
// ----------------------------------------------------------------------------
package bmsh_pkg;

    // request codes
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // widths of the beat fields
    localparam int ROW_FIELD_BITS = 8;
    localparam int INDEX_BITS     = 8;
    localparam int HIST_OUT_BITS  = 16;
    localparam int CNT_OUT_BITS   = 5;

    // control from the sequencer to every row lane
    typedef struct packed {
        logic rd_en;   // look up the entry (accept cycle)
        logic wr_en;   // update the entry (while busy)
        logic scan;    // scan beat when set, read beat when clear
    } t_lane_ctl;

endpackage

/* design/bmsh_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsh_lane
// One row slot of the matrix: holds history and count of every column of
// that slot and performs the read-modify-write of one entry per item.
// ----------------------------------------------------------------------------
module bmsh_lane
    import bmsh_pkg::*;
#(
    parameter int COLUMNS      = 8,
    parameter int HISTORY_BITS = 16,
    parameter int MAX_COUNT    = 16,
    parameter int SLOT         = 0,
    parameter int COL_W        = 3,
    parameter int CNT_W        = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    input  logic [COL_W-1:0]        i_col,
    input  logic [INDEX_BITS-1:0]   i_index,
    input  logic                    i_bit,
    output logic                    o_hit,
    output logic [HISTORY_BITS-1:0] o_hist,
    output logic [CNT_W-1:0]        o_cnt
);

    localparam int BASE = SLOT * COLUMNS;

    logic [HISTORY_BITS-1:0] mem_hist [COLUMNS];
    logic [CNT_W-1:0]        mem_cnt  [COLUMNS];
    logic [COLUMNS-1:0]      r_vld;

    logic [COL_W-1:0]        r_addr;
    logic                    r_hit;
    logic                    r_bit;
    logic                    r_rd_vld;
    logic [HISTORY_BITS-1:0] r_rd_hist;
    logic [CNT_W-1:0]        r_rd_cnt;

    logic                    in_range;
    logic [INDEX_BITS:0]     offset;
    logic [COL_W-1:0]        addr;
    logic [HISTORY_BITS-1:0] cur_hist;
    logic [CNT_W-1:0]        cur_cnt;
    logic [HISTORY_BITS-1:0] new_hist;
    logic [CNT_W-1:0]        new_cnt;

    // button index = slot * COLUMNS + column
    assign in_range = ({1'b0, i_index} >= (INDEX_BITS+1)'(BASE)) &&
                      ({1'b0, i_index} <  (INDEX_BITS+1)'(BASE + COLUMNS));
    assign offset   = {1'b0, i_index} - (INDEX_BITS+1)'(BASE);

    always_comb begin
        if (i_ctl.scan) begin
            addr = i_col;
        end else if (in_range) begin
            addr = offset[COL_W-1:0];
        end else begin
            addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_addr    <= addr;
            r_bit     <= i_bit;
            r_rd_hist <= mem_hist[addr];
            r_rd_cnt  <= mem_cnt[addr];
            r_rd_vld  <= r_vld[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.rd_en) begin
            r_hit <= i_ctl.scan | in_range;
        end
    end

    // entries never written since reset read as zero
    assign cur_hist = r_rd_vld ? r_rd_hist : '0;
    assign cur_cnt  = r_rd_vld ? r_rd_cnt  : '0;

    always_comb begin
        if (i_ctl.scan) begin
            new_hist = (cur_hist << 1) | HISTORY_BITS'(r_bit);
            new_cnt  = (cur_cnt < CNT_W'(MAX_COUNT)) ? cur_cnt + CNT_W'(1)
                                                     : CNT_W'(MAX_COUNT);
        end else begin
            new_hist = cur_hist;
            new_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && r_hit) begin
            mem_hist[r_addr] <= new_hist;
            mem_cnt[r_addr]  <= new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en && r_hit) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    assign o_hit  = r_hit;
    assign o_hist = cur_hist;
    assign o_cnt  = cur_cnt;

endmodule

/* design/bmsh_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsh_merge
// Combines the row lanes' read data into one result beat and registers it.
// ----------------------------------------------------------------------------
module bmsh_merge
    import bmsh_pkg::*;
#(
    parameter int ROWS         = 8,
    parameter int HISTORY_BITS = 16,
    parameter int CNT_W        = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_index_err,
    input  logic [ROWS-1:0]              i_hit,
    input  logic [ROWS*HISTORY_BITS-1:0] i_hist,
    input  logic [ROWS*CNT_W-1:0]        i_cnt,
    output logic                         o_valid,
    output logic [HIST_OUT_BITS-1:0]     o_history,
    output logic [CNT_OUT_BITS-1:0]      o_sample_count,
    output logic                         o_has_samples,
    output logic                         o_index_error
);

    localparam int HW = (HISTORY_BITS > HIST_OUT_BITS) ? HISTORY_BITS : HIST_OUT_BITS;
    localparam int CW = (CNT_W > CNT_OUT_BITS) ? CNT_W : CNT_OUT_BITS;

    logic [HISTORY_BITS-1:0]  sel_hist;
    logic [CNT_W-1:0]         sel_cnt;
    logic [HW-1:0]            hist_ext;
    logic [CW-1:0]            cnt_ext;

    logic                     r_valid;
    logic [HIST_OUT_BITS-1:0] r_history;
    logic [CNT_OUT_BITS-1:0]  r_sample_count;
    logic                     r_has_samples;
    logic                     r_index_error;

    // at most one lane hits on a read
    always_comb begin
        sel_hist = '0;
        sel_cnt  = '0;
        for (int s = 0; s < ROWS; s++) begin
            if (i_hit[s]) begin
                sel_hist = sel_hist | i_hist[s*HISTORY_BITS +: HISTORY_BITS];
                sel_cnt  = sel_cnt  | i_cnt[s*CNT_W +: CNT_W];
            end
        end
    end

    assign hist_ext = HW'(sel_hist);
    assign cnt_ext  = CW'(sel_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_history      <= hist_ext[HIST_OUT_BITS-1:0];
            r_sample_count <= cnt_ext[CNT_OUT_BITS-1:0];
            r_has_samples  <= (sel_cnt != '0);
            r_index_error  <= i_index_err;
        end
    end

    assign o_valid        = r_valid;
    assign o_history      = r_history;
    assign o_sample_count = r_sample_count;
    assign o_has_samples  = r_has_samples;
    assign o_index_error  = r_index_error;

endmodule

/* design/button_matrix_scan_history.sv */
`timescale 1ns / 1ps
// A read result strobes on o_valid from the merge result register, loaded from the lane lookup registers.
// The block takes no new item until the read-modify-write of one column entry in every
// row lane is through (lookup on accept, then update while busy).
// Scan beats give no result. The receiver cannot stall the result beat.
// Reset (sync, active low) clears all histories, counts and the column counter
// at once through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// button_matrix_scan_history
// Column-by-column button matrix scanner with per-button sample history and
// sample count; one lane per row slot, merged on reads.
// ----------------------------------------------------------------------------
module button_matrix_scan_history
    import bmsh_pkg::*;
#(
    parameter int COLUMNS      = 8,
    parameter int ROWS         = 8,
    parameter int HISTORY_BITS = 16,
    parameter int MAX_COUNT    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [ROW_FIELD_BITS-1:0] i_row_levels,
    input  logic [INDEX_BITS-1:0]     i_read_index,
    output logic                      o_valid,
    output logic [HIST_OUT_BITS-1:0]  o_history,
    output logic [CNT_OUT_BITS-1:0]   o_sample_count,
    output logic                      o_has_samples,
    output logic                      o_index_error
);

    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CNT_W   = $clog2(MAX_COUNT + 1);
    localparam int BUTTONS = COLUMNS * ROWS;

    logic                         r_busy;
    logic                         r_req;
    logic [INDEX_BITS-1:0]        r_index;
    logic [COL_W-1:0]             r_col;
    logic [COL_W-1:0]             n_col;

    logic                         accept;
    t_lane_ctl                    lane_ctl;
    logic [ROWS-1:0]              pressed;
    logic [ROWS-1:0]              lane_hit;
    logic [ROWS*HISTORY_BITS-1:0] lane_hist;
    logic [ROWS*CNT_W-1:0]        lane_cnt;
    logic                         index_err;

    assign accept = start && !r_busy;

    always_comb begin
        lane_ctl.rd_en = accept;
        lane_ctl.wr_en = r_busy;
        lane_ctl.scan  = accept ? (i_req_type == REQ_SCAN) : (r_req == REQ_SCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
        end else begin
            r_busy <= accept;
            r_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_index <= i_read_index;
        end
    end

    always_comb begin
        n_col = r_col;
        if (r_busy && (r_req == REQ_SCAN)) begin
            if (r_col == COL_W'(COLUMNS - 1)) begin
                n_col = '0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    assign index_err = ({1'b0, r_index} >= (INDEX_BITS+1)'(BUTTONS));

    genvar s;
    generate
        for (s = 0; s < ROWS; s++) begin : g_lane
            // row slot s takes shifted bit ROWS-1-s; rows past the field read released
            localparam int RBIT = ROWS - 1 - s;
            if (RBIT < ROW_FIELD_BITS) begin : g_bit
                assign pressed[s] = ~i_row_levels[RBIT];
            end else begin : g_nobit
                assign pressed[s] = 1'b0;
            end

            bmsh_lane #(
                .COLUMNS      (COLUMNS),
                .HISTORY_BITS (HISTORY_BITS),
                .MAX_COUNT    (MAX_COUNT),
                .SLOT         (s),
                .COL_W        (COL_W),
                .CNT_W        (CNT_W)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lane_ctl),
                .i_col   (r_col),
                .i_index (accept ? i_read_index : r_index),
                .i_bit   (pressed[s]),
                .o_hit   (lane_hit[s]),
                .o_hist  (lane_hist[s*HISTORY_BITS +: HISTORY_BITS]),
                .o_cnt   (lane_cnt[s*CNT_W +: CNT_W])
            );
        end
    endgenerate

    bmsh_merge #(
        .ROWS         (ROWS),
        .HISTORY_BITS (HISTORY_BITS),
        .CNT_W        (CNT_W)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (r_busy && (r_req == REQ_READ)),
        .i_index_err    (index_err),
        .i_hit          (lane_hit),
        .i_hist         (lane_hist),
        .i_cnt          (lane_cnt),
        .o_valid        (o_valid),
        .o_history      (o_history),
        .o_sample_count (o_sample_count),
        .o_has_samples  (o_has_samples),
        .o_index_error  (o_index_error)
    );

    assign busy = r_busy;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accepted beat did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy) else $error("busy held for more than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result beat while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |->
            (o_history == '0 && o_sample_count == '0 && !o_has_samples))
        else $error("index error beat carries data");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS - 1)) else $error("column counter out of range");
`endif

endmodule
